[design/fa_pkg.sv]
// ----------------------------------------------------------------------------
// fa_pkg
// Shared widths, codes, state type and helpers of the frame allocator.
// ----------------------------------------------------------------------------
package fa_pkg;

  localparam int FRAMES     = 64;
  localparam int FRAME_W    = 6;
  localparam int CNT_W      = 7;
  localparam int OWNER_W    = 8;
  localparam int PAGE_W     = 16;
  localparam int ENTRY_W    = OWNER_W + PAGE_W;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int FIU_W      = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [FIU_W-1:0] FIU_RESET = FIU_W'(FRAMES);

  // register word index, taken from paddr above the byte bits
  localparam logic REG_FRAMES_IN_USE = 1'b0;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FREE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FREE_SCAN,
    S_REL_POS,
    S_RANK,
    S_EVICT_RD,
    S_EVICT_DATA,
    S_QUERY_DATA,
    S_FINISH
  } state_t;

  // frame count actually managed: zero acts as one, clamp at FRAMES
  function automatic logic [CNT_W-1:0] active_frames(input logic [FIU_W-1:0] fiu);
    logic [CNT_W-1:0] n;
    if (fiu == '0) begin
      n = CNT_W'(1);
    end else if (fiu > FIU_W'(FRAMES)) begin
      n = CNT_W'(FRAMES);
    end else begin
      n = CNT_W'(fiu);
    end
    return n;
  endfunction

endpackage

[design/fa_if.sv]
// ----------------------------------------------------------------------------
// fa_req_if / fa_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface fa_req_if;
  logic                         valid;
  logic                         ready;
  logic [fa_pkg::CMD_W-1:0]     command;
  logic [fa_pkg::FRAME_W-1:0]   frame;
  logic [fa_pkg::OWNER_W-1:0]   owner;
  logic [fa_pkg::PAGE_W-1:0]    virtual_page;

  modport source (output valid, command, frame, owner, virtual_page, input ready);
  modport sink   (input valid, command, frame, owner, virtual_page, output ready);
endinterface

interface fa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fa_pkg::FRAME_W-1:0]   frame_out;
  logic                         evicted;
  logic [fa_pkg::OWNER_W-1:0]   entry_owner;
  logic [fa_pkg::PAGE_W-1:0]    entry_page;
  logic [fa_pkg::STATUS_W-1:0]  status;

  modport source (output valid, frame_out, evicted, entry_owner, entry_page, status,
                  input ready);
  modport sink   (input valid, frame_out, evicted, entry_owner, entry_page, status,
                  output ready);
endinterface

[design/fa_ram.sv]
// ----------------------------------------------------------------------------
// fa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/fa_apb_regs.sv]
// ----------------------------------------------------------------------------
// fa_apb_regs
// APB register slave holding the managed frame count.
// ----------------------------------------------------------------------------
module fa_apb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [fa_pkg::FIU_W-1:0]      frames_in_use
);

  logic [fa_pkg::FIU_W-1:0] fiu_r;
  logic [fa_pkg::FIU_W-1:0] fiu_nxt;
  logic                     hit;

  assign hit = (paddr[fa_pkg::CFG_ADDR_W-1] == fa_pkg::REG_FRAMES_IN_USE);

  always_comb begin
    fiu_nxt = fiu_r;
    if (psel && penable && pwrite && hit) begin
      fiu_nxt = pwdata[fa_pkg::FIU_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r <= fa_pkg::FIU_RESET;
    end else begin
      fiu_r <= fiu_nxt;
    end
  end

  assign prdata        = hit ? fa_pkg::CFG_DATA_W'(fiu_r) : '0;
  assign pready        = 1'b1;
  assign frames_in_use = fiu_r;

endmodule

[design/frame_allocator_fifo_evict.sv]
// ----------------------------------------------------------------------------
// frame_allocator_fifo_evict
// Physical frame allocator with oldest-first eviction.
// ----------------------------------------------------------------------------
// One request is handled at a time; the result sits in an output register so
// the next request can be taken while it waits. An allocate scans the busy
// bits one frame per cycle. A granted release and an eviction each run one
// pass over the age-position memory, one frame per cycle. Age order is kept
// as a queue position per frame; the pass shifts positions down after a
// removal. Owner and page live in a memory; per-frame written bits make
// never-written entries read as zero, so no clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module frame_allocator_fifo_evict (
  input  logic                          clk,
  input  logic                          rst_n,
  fa_req_if.sink                        in_ch,
  fa_rsp_if.source                      out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fa_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [fa_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [fa_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready
);

  localparam int FW = fa_pkg::FRAME_W;
  localparam int CW = fa_pkg::CNT_W;
  localparam int OW = fa_pkg::OWNER_W;
  localparam int PW = fa_pkg::PAGE_W;
  localparam int SW = fa_pkg::STATUS_W;

  fa_pkg::state_t state_r, state_nxt;

  logic [fa_pkg::FIU_W-1:0] frames_in_use;
  logic [CW-1:0]            n_active;

  // request being worked on
  logic [fa_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [FW-1:0]            fr_r, fr_nxt;
  logic [OW-1:0]            own_r, own_nxt;
  logic [PW-1:0]            pg_r, pg_nxt;

  logic [CW-1:0]            scan_r, scan_nxt;
  logic                     rel_mode_r, rel_mode_nxt;
  logic [FW-1:0]            rel_pos_r, rel_pos_nxt;
  logic [FW-1:0]            victim_r, victim_nxt;
  logic [fa_pkg::FRAMES-1:0] busy_r, busy_nxt;
  logic [fa_pkg::FRAMES-1:0] written_r, written_nxt;
  logic [CW-1:0]            count_r, count_nxt;

  logic [FW-1:0]            res_frame_r, res_frame_nxt;
  logic                     res_evicted_r, res_evicted_nxt;
  logic [OW-1:0]            res_owner_r, res_owner_nxt;
  logic [PW-1:0]            res_page_r, res_page_nxt;
  logic [SW-1:0]            res_status_r, res_status_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [FW-1:0]            out_frame_r, out_frame_nxt;
  logic                     out_evicted_r, out_evicted_nxt;
  logic [OW-1:0]            out_owner_r, out_owner_nxt;
  logic [PW-1:0]            out_page_r, out_page_nxt;
  logic [SW-1:0]            out_status_r, out_status_nxt;

  logic                     pos_we;
  logic [FW-1:0]            pos_waddr, pos_wdata, pos_raddr, pos_rdata;
  logic                     ent_we;
  logic [FW-1:0]            ent_waddr, ent_raddr;
  logic [fa_pkg::ENTRY_W-1:0] ent_wdata, ent_rdata;

  logic                     in_ready;
  logic                     fr_out_of_range;
  logic [FW-1:0]            scan_idx;
  logic [FW-1:0]            proc_idx;
  logic                     out_free;

  fa_apb_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frames_in_use (frames_in_use)
  );

  // queue position of each busy frame, 0 is the oldest
  fa_ram #(.WIDTH(FW), .DEPTH(fa_pkg::FRAMES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // owner and page per frame
  fa_ram #(.WIDTH(fa_pkg::ENTRY_W), .DEPTH(fa_pkg::FRAMES)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign n_active        = fa_pkg::active_frames(frames_in_use);
  assign fr_out_of_range = ({1'b0, fr_r} >= n_active);
  assign scan_idx        = scan_r[FW-1:0];
  assign proc_idx        = scan_r[FW-1:0] - FW'(1);
  assign in_ready        = (state_r == fa_pkg::S_IDLE);
  assign out_free        = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fa_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = fa_pkg::S_DECODE;
        end
      end
      fa_pkg::S_DECODE: begin
        case (cmd_r)
          fa_pkg::CMD_ALLOC: begin
            state_nxt = fa_pkg::S_FREE_SCAN;
          end
          fa_pkg::CMD_RELEASE: begin
            if (fr_out_of_range || !busy_r[fr_r]) begin
              state_nxt = fa_pkg::S_FINISH;
            end else begin
              state_nxt = fa_pkg::S_REL_POS;
            end
          end
          fa_pkg::CMD_QUERY: begin
            state_nxt = fr_out_of_range ? fa_pkg::S_FINISH : fa_pkg::S_QUERY_DATA;
          end
          default: begin
            state_nxt = fa_pkg::S_FINISH;
          end
        endcase
      end
      fa_pkg::S_FREE_SCAN: begin
        if (!busy_r[scan_idx]) begin
          state_nxt = fa_pkg::S_FINISH;
        end else if (scan_r == n_active - CW'(1)) begin
          state_nxt = fa_pkg::S_RANK;
        end
      end
      fa_pkg::S_REL_POS: begin
        state_nxt = fa_pkg::S_RANK;
      end
      fa_pkg::S_RANK: begin
        if (scan_r == CW'(fa_pkg::FRAMES)) begin
          state_nxt = rel_mode_r ? fa_pkg::S_FINISH : fa_pkg::S_EVICT_RD;
        end
      end
      fa_pkg::S_EVICT_RD: begin
        state_nxt = fa_pkg::S_EVICT_DATA;
      end
      fa_pkg::S_EVICT_DATA: begin
        state_nxt = fa_pkg::S_FINISH;
      end
      fa_pkg::S_QUERY_DATA: begin
        state_nxt = fa_pkg::S_FINISH;
      end
      fa_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = fa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fa_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt         = cmd_r;
    fr_nxt          = fr_r;
    own_nxt         = own_r;
    pg_nxt          = pg_r;
    scan_nxt        = scan_r;
    rel_mode_nxt    = rel_mode_r;
    rel_pos_nxt     = rel_pos_r;
    victim_nxt      = victim_r;
    busy_nxt        = busy_r;
    written_nxt     = written_r;
    count_nxt       = count_r;
    res_frame_nxt   = res_frame_r;
    res_evicted_nxt = res_evicted_r;
    res_owner_nxt   = res_owner_r;
    res_page_nxt    = res_page_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_frame_nxt   = out_frame_r;
    out_evicted_nxt = out_evicted_r;
    out_owner_nxt   = out_owner_r;
    out_page_nxt    = out_page_r;
    out_status_nxt  = out_status_r;
    pos_we          = 1'b0;
    pos_waddr       = proc_idx;
    pos_wdata       = '0;
    pos_raddr       = scan_idx;
    ent_we          = 1'b0;
    ent_waddr       = fr_r;
    ent_wdata       = {own_r, pg_r};
    ent_raddr       = fr_r;

    case (state_r)
      fa_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.command;
          fr_nxt  = in_ch.frame;
          own_nxt = in_ch.owner;
          pg_nxt  = in_ch.virtual_page;
        end
      end
      fa_pkg::S_DECODE: begin
        res_frame_nxt   = fr_r;
        res_evicted_nxt = 1'b0;
        res_owner_nxt   = '0;
        res_page_nxt    = '0;
        res_status_nxt  = fa_pkg::ST_OK;
        scan_nxt        = '0;
        pos_raddr       = fr_r;
        case (cmd_r)
          fa_pkg::CMD_ALLOC: begin
            res_frame_nxt = '0;
          end
          fa_pkg::CMD_RELEASE: begin
            if (fr_out_of_range) begin
              res_status_nxt = fa_pkg::ST_RANGE;
            end else if (!busy_r[fr_r]) begin
              res_status_nxt = fa_pkg::ST_FREE;
            end
          end
          fa_pkg::CMD_QUERY: begin
            if (fr_out_of_range) begin
              res_status_nxt = fa_pkg::ST_RANGE;
            end
          end
          default: begin
            res_frame_nxt = '0;
          end
        endcase
      end
      fa_pkg::S_FREE_SCAN: begin
        if (!busy_r[scan_idx]) begin
          busy_nxt[scan_idx]    = 1'b1;
          written_nxt[scan_idx] = 1'b1;
          count_nxt             = count_r + CW'(1);
          pos_we                = 1'b1;
          pos_waddr             = scan_idx;
          pos_wdata             = count_r[FW-1:0];
          ent_we                = 1'b1;
          ent_waddr             = scan_idx;
          res_frame_nxt         = scan_idx;
        end else if (scan_r == n_active - CW'(1)) begin
          scan_nxt     = '0;
          rel_mode_nxt = 1'b0;
        end else begin
          scan_nxt = scan_r + CW'(1);
        end
      end
      fa_pkg::S_REL_POS: begin
        rel_pos_nxt  = pos_rdata;
        rel_mode_nxt = 1'b1;
        scan_nxt     = '0;
      end
      fa_pkg::S_RANK: begin
        // read frame scan_r, adjust frame scan_r-1 from last cycle's read
        scan_nxt = scan_r + CW'(1);
        if (scan_r != '0 && busy_r[proc_idx]) begin
          if (rel_mode_r) begin
            if (pos_rdata > rel_pos_r) begin
              pos_we    = 1'b1;
              pos_wdata = pos_rdata - FW'(1);
            end
          end else begin
            pos_we = 1'b1;
            if (pos_rdata == '0) begin
              // oldest frame goes to the back of the queue
              victim_nxt = proc_idx;
              pos_wdata  = count_r[FW-1:0] - FW'(1);
            end else begin
              pos_wdata = pos_rdata - FW'(1);
            end
          end
        end
        if (scan_r == CW'(fa_pkg::FRAMES) && rel_mode_r) begin
          busy_nxt[fr_r] = 1'b0;
          count_nxt      = count_r - CW'(1);
        end
      end
      fa_pkg::S_EVICT_RD: begin
        ent_raddr = victim_r;
      end
      fa_pkg::S_EVICT_DATA: begin
        res_frame_nxt         = victim_r;
        res_evicted_nxt       = 1'b1;
        res_owner_nxt         = written_r[victim_r] ? ent_rdata[fa_pkg::ENTRY_W-1 -: OW] : '0;
        res_page_nxt          = written_r[victim_r] ? ent_rdata[PW-1:0] : '0;
        ent_we                = 1'b1;
        ent_waddr             = victim_r;
        written_nxt[victim_r] = 1'b1;
      end
      fa_pkg::S_QUERY_DATA: begin
        res_owner_nxt = written_r[fr_r] ? ent_rdata[fa_pkg::ENTRY_W-1 -: OW] : '0;
        res_page_nxt  = written_r[fr_r] ? ent_rdata[PW-1:0] : '0;
      end
      fa_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_frame_nxt   = res_frame_r;
          out_evicted_nxt = res_evicted_r;
          out_owner_nxt   = res_owner_r;
          out_page_nxt    = res_page_r;
          out_status_nxt  = res_status_r;
        end
      end
      default: begin
        scan_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fa_pkg::S_IDLE;
      busy_r      <= '0;
      written_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      rel_mode_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      written_r   <= written_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      scan_r      <= scan_nxt;
      rel_mode_r  <= rel_mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    fr_r          <= fr_nxt;
    own_r         <= own_nxt;
    pg_r          <= pg_nxt;
    rel_pos_r     <= rel_pos_nxt;
    victim_r      <= victim_nxt;
    res_frame_r   <= res_frame_nxt;
    res_evicted_r <= res_evicted_nxt;
    res_owner_r   <= res_owner_nxt;
    res_page_r    <= res_page_nxt;
    res_status_r  <= res_status_nxt;
    out_frame_r   <= out_frame_nxt;
    out_evicted_r <= out_evicted_nxt;
    out_owner_r   <= out_owner_nxt;
    out_page_r    <= out_page_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.frame_out   = out_frame_r;
  assign out_ch.evicted     = out_evicted_r;
  assign out_ch.entry_owner = out_owner_r;
  assign out_ch.entry_page  = out_page_r;
  assign out_ch.status      = out_status_r;

  // queue length always matches the number of busy frames between requests
  a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fa_pkg::S_IDLE |-> int'(count_r) == $countones(busy_r))
    else $error("age queue length differs from busy frame count");

  // the evicted frame was found busy during the rank pass
  a_victim_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fa_pkg::S_EVICT_DATA |-> busy_r[victim_r])
    else $error("eviction of a free frame");

  // an eviction always reports ok
  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evicted_r |-> out_status_r == fa_pkg::ST_OK)
    else $error("evicted result with non-ok status");

  // a finished request lands in the output register
  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fa_pkg::S_FINISH && out_free |=> out_valid_r && state_r == fa_pkg::S_IDLE)
    else $error("finished request did not reach the output");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FIFO-eviction frame allocator.
// Starts with a short table of directed requests and then runs phases of
// random requests, each phase under a new frame count. A behavioral copy of
// the frame table (busy bits, age order, owner and page) predicts every
// result, and an ordered queue of those predictions is matched against the
// result channel field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS   = 530;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [FRAME_W-1:0] frame;
    logic [OWNER_W-1:0] owner;
    logic [PAGE_W-1:0]  virtual_page;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_out;
    logic                evicted;
    logic [OWNER_W-1:0]  entry_owner;
    logic [PAGE_W-1:0]   entry_page;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic               typed;
    req_t               req;
    rsp_t               rsp;
    logic [FIU_W-1:0]   count;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fa_req_if req_bus();
  fa_rsp_if rsp_bus();

  frame_allocator_fifo_evict i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_bus),
    .out_ch  (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // frame table mirror
  bit                 frame_taken [FRAMES];
  int                 age_order [$];
  logic [OWNER_W-1:0] owner_mem [FRAMES];
  logic [PAGE_W-1:0]  page_mem [FRAMES];
  logic [FIU_W-1:0]   frame_count_reg;

  rsp_t pending_results [$];

  int mismatch_count;
  int n_alloc, n_evict, n_rel_ok, n_rel_free, n_range, n_query, n_unused;
  int n_requests, n_settings, n_holds;
  int burst_left;
  bit gaps_on;
  bit hold_off_req;

  function automatic int managed_frames();
    if (frame_count_reg == '0) return 1;
    if (frame_count_reg > FIU_W'(FRAMES)) return FRAMES;
    return int'(frame_count_reg);
  endfunction

  function automatic void drop_from_age_order(int f);
    int i;
    for (i = 0; i < age_order.size(); i++) begin
      if (age_order[i] == f) begin
        age_order.delete(i);
        break;
      end
    end
  endfunction

  // applies one request to the mirror and returns the result it should give
  function automatic rsp_t step_frame_table(req_t r);
    rsp_t res;
    int   n;
    int   sel;
    int   i;
    bit   found;
    res   = '0;
    n     = managed_frames();
    sel   = 0;
    found = 1'b0;
    case (r.command)
      CMD_ALLOC: begin
        n_alloc++;
        for (i = 0; i < n; i++) begin
          if (!found && !frame_taken[i]) begin
            sel   = i;
            found = 1'b1;
          end
        end
        if (!found && age_order.size() != 0) begin
          sel             = age_order.pop_front() % FRAMES;
          res.evicted     = 1'b1;
          res.entry_owner = owner_mem[sel];
          res.entry_page  = page_mem[sel];
          n_evict++;
        end
        if (frame_taken[sel]) drop_from_age_order(sel);
        frame_taken[sel] = 1'b1;
        owner_mem[sel]   = r.owner;
        page_mem[sel]    = r.virtual_page;
        if (age_order.size() < FRAMES) age_order.push_back(sel);
        res.frame_out = FRAME_W'(sel);
      end
      CMD_RELEASE: begin
        res.frame_out = r.frame;
        if (r.frame >= n) begin
          res.status = ST_RANGE;
          n_range++;
        end else if (!frame_taken[r.frame]) begin
          res.status = ST_FREE;
          n_rel_free++;
        end else begin
          drop_from_age_order(int'(r.frame));
          frame_taken[r.frame] = 1'b0;
          n_rel_ok++;
        end
      end
      CMD_QUERY: begin
        n_query++;
        res.frame_out = r.frame;
        if (r.frame >= n) begin
          res.status = ST_RANGE;
          n_range++;
        end else begin
          res.entry_owner = owner_mem[r.frame];
          res.entry_page  = page_mem[r.frame];
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    return res;
  endfunction

  // random request, biased toward frames that are actually busy or in range
  function automatic req_t pick_request();
    req_t r;
    int   n;
    int   roll;
    int   i;
    int   busy_list [$];
    n              = managed_frames();
    r.frame        = FRAME_W'($urandom);
    r.owner        = OWNER_W'($urandom);
    r.virtual_page = PAGE_W'($urandom);
    roll           = $urandom_range(0, 99);
    if (roll < 45) begin
      r.command = CMD_ALLOC;
    end else if (roll < 70) begin
      r.command = CMD_RELEASE;
      for (i = 0; i < FRAMES; i++) begin
        if (frame_taken[i]) busy_list.push_back(i);
      end
      if (busy_list.size() != 0 && $urandom_range(0, 99) < 75) begin
        r.frame = FRAME_W'(busy_list[$urandom_range(0, busy_list.size() - 1)]);
      end
    end else if (roll < 95) begin
      r.command = CMD_QUERY;
      if ($urandom_range(0, 3) != 0) r.frame = FRAME_W'($urandom_range(0, n - 1));
    end else begin
      r.command = CMD_UNUSED;
    end
    if ($urandom_range(0, 15) == 0) r.owner = roll[0] ? '1 : '0;
    if ($urandom_range(0, 15) == 0) r.virtual_page = roll[1] ? '1 : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
  endtask

  // called at a rising edge; returns at the edge the request is taken
  task automatic offer_request(req_t r, logic typed, rsp_t typed_rsp);
    int   gap;
    rsp_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_bus.valid        <= 1'b1;
    req_bus.command      <= r.command;
    req_bus.frame        <= r.frame;
    req_bus.owner        <= r.owner;
    req_bus.virtual_page <= r.virtual_page;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    predicted = step_frame_table(r);
    pending_results.push_back(typed ? typed_rsp : predicted);
    n_requests++;
  endtask

  // frame count changes only with nothing in flight
  task automatic write_frame_count(logic [FIU_W-1:0] count,
                                   logic [CFG_DATA_W-FIU_W-1:0] upper);
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FRAMES_IN_USE, 2'b00};
    pwdata  <= {upper, count};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    frame_count_reg = count;
    n_settings++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== CFG_DATA_W'(count)) report_mismatch("frame count readback", prdata, count);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic dir_row_t row_req(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] fr,
                                       logic [OWNER_W-1:0] own, logic [PAGE_W-1:0] pg);
    dir_row_t row;
    row     = '0;
    row.kind = ROW_REQ;
    row.req = '{cmd, fr, own, pg};
    return row;
  endfunction

  function automatic dir_row_t row_exp(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] fr,
                                       logic [OWNER_W-1:0] own, logic [PAGE_W-1:0] pg,
                                       logic [FRAME_W-1:0] fo, logic ev,
                                       logic [OWNER_W-1:0] eo, logic [PAGE_W-1:0] ep,
                                       logic [STATUS_W-1:0] st);
    dir_row_t row;
    row       = row_req(cmd, fr, own, pg);
    row.typed = 1'b1;
    row.rsp   = '{fo, ev, eo, ep, st};
    return row;
  endfunction

  function automatic dir_row_t row_cfg(logic [FIU_W-1:0] count);
    dir_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.count = count;
    return row;
  endfunction

  // result checker
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      got = '{rsp_bus.frame_out, rsp_bus.evicted, rsp_bus.entry_owner,
              rsp_bus.entry_page, rsp_bus.status};
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting", got, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.frame_out !== want.frame_out)
          report_mismatch("frame_out", got.frame_out, want.frame_out);
        if (got.evicted !== want.evicted)
          report_mismatch("evicted", got.evicted, want.evicted);
        if (got.entry_owner !== want.entry_owner)
          report_mismatch("entry_owner", got.entry_owner, want.entry_owner);
        if (got.entry_page !== want.entry_page)
          report_mismatch("entry_page", got.entry_page, want.entry_page);
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  int idle_cycles;
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
        (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver stall patterns, plus the occasional long hold-off
  initial begin
    int       mode;
    int       left;
    int       cyc;
    bit [7:0] pattern;
    mode = 0;
    left = 0;
    cyc  = 0;
    pattern = 8'hff;
    rsp_bus.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n_holds++;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode    = $urandom_range(0, 3);
        left    = $urandom_range(20, 120);
        pattern = 8'($urandom_range(1, 255));
      end
      left--;
      cyc++;
      case (mode)
        0: rsp_bus.ready <= 1'b1;
        1: rsp_bus.ready <= 1'($urandom_range(0, 1));
        2: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
        default: rsp_bus.ready <= pattern[cyc % 8];
      endcase
      @(posedge clk);
    end
  end

  initial begin
    dir_row_t         rows [$];
    req_t             r;
    logic [FIU_W-1:0] count;
    int               k;
    int               roll;
    int               len;
    int               phase;
    int               random_items;

    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_bus.valid        <= 1'b0;
    req_bus.command      <= CMD_ALLOC;
    req_bus.frame        <= '0;
    req_bus.owner        <= '0;
    req_bus.virtual_page <= '0;
    hold_off_req = 1'b0;
    gaps_on      = 1'b1;
    burst_left   = 0;
    frame_count_reg = FIU_RESET;
    for (k = 0; k < FRAMES; k++) begin
      frame_taken[k] = 1'b0;
      owner_mem[k]   = '0;
      page_mem[k]    = '0;
    end

    // directed: tables read zero after reset, free/busy/stale entries,
    // out-of-range frames, clamped frame counts, eviction of a frame
    // above the current count
    rows.push_back(row_exp(CMD_QUERY,   6'd0,  8'h00, 16'h0000, 6'd0,  1'b0, 8'h00, 16'h0000, ST_OK));
    rows.push_back(row_exp(CMD_QUERY,   6'd63, 8'h00, 16'h0000, 6'd63, 1'b0, 8'h00, 16'h0000, ST_OK));
    rows.push_back(row_exp(CMD_RELEASE, 6'd63, 8'h00, 16'h0000, 6'd63, 1'b0, 8'h00, 16'h0000, ST_FREE));
    rows.push_back(row_exp(CMD_ALLOC,   6'd63, 8'hff, 16'hffff, 6'd0,  1'b0, 8'h00, 16'h0000, ST_OK));
    rows.push_back(row_exp(CMD_ALLOC,   6'd0,  8'h00, 16'h0000, 6'd1,  1'b0, 8'h00, 16'h0000, ST_OK));
    rows.push_back(row_exp(CMD_QUERY,   6'd0,  8'h00, 16'h0000, 6'd0,  1'b0, 8'hff, 16'hffff, ST_OK));
    rows.push_back(row_exp(CMD_RELEASE, 6'd0,  8'h00, 16'h0000, 6'd0,  1'b0, 8'h00, 16'h0000, ST_OK));
    rows.push_back(row_exp(CMD_QUERY,   6'd0,  8'h00, 16'h0000, 6'd0,  1'b0, 8'hff, 16'hffff, ST_OK));
    rows.push_back(row_exp(CMD_UNUSED,  6'd63, 8'hff, 16'hffff, 6'd0,  1'b0, 8'h00, 16'h0000, ST_OK));
    rows.push_back(row_cfg(7'd2));
    rows.push_back(row_exp(CMD_RELEASE, 6'd2,  8'h00, 16'h0000, 6'd2,  1'b0, 8'h00, 16'h0000, ST_RANGE));
    rows.push_back(row_exp(CMD_QUERY,   6'd63, 8'h00, 16'h0000, 6'd63, 1'b0, 8'h00, 16'h0000, ST_RANGE));
    rows.push_back(row_req(CMD_ALLOC,   6'd0,  8'h12, 16'h3456));
    rows.push_back(row_req(CMD_ALLOC,   6'd0,  8'ha5, 16'h5a5a));
    rows.push_back(row_req(CMD_ALLOC,   6'd0,  8'h5a, 16'ha5a5));
    rows.push_back(row_cfg(7'd0));
    rows.push_back(row_exp(CMD_QUERY,   6'd1,  8'h00, 16'h0000, 6'd1,  1'b0, 8'h00, 16'h0000, ST_RANGE));
    rows.push_back(row_req(CMD_ALLOC,   6'd0,  8'h3c, 16'hc3c3));
    rows.push_back(row_req(CMD_RELEASE, 6'd1,  8'h00, 16'h0000));
    rows.push_back(row_cfg(7'd127));
    rows.push_back(row_req(CMD_RELEASE, 6'd1,  8'h00, 16'h0000));
    rows.push_back(row_req(CMD_QUERY,   6'd63, 8'h00, 16'h0000));
    rows.push_back(row_req(CMD_ALLOC,   6'd0,  8'h81, 16'h8001));
    rows.push_back(row_cfg(7'd64));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < rows.size(); k++) begin
      if (rows[k].kind == ROW_CFG) begin
        write_frame_count(rows[k].count, '0);
      end else begin
        offer_request(rows[k].req, rows[k].typed, rows[k].rsp);
      end
    end

    // random phases, mostly small frame counts so that eviction is common
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase++;
      roll = $urandom_range(0, 99);
      if (roll < 30)      count = FIU_W'($urandom_range(1, 4));
      else if (roll < 55) count = FIU_W'($urandom_range(5, 12));
      else if (roll < 65) count = '0;
      else if (roll < 75) count = FIU_W'(FRAMES);
      else if (roll < 85) count = FIU_W'($urandom_range(65, 127));
      else                count = FIU_W'($urandom_range(13, 63));
      write_frame_count(count, $urandom_range(0, 1) ? (CFG_DATA_W-FIU_W)'($urandom) : '0);
      if (phase == 2 || phase % 7 == 0) hold_off_req = 1'b1;
      gaps_on = ($urandom_range(0, 3) != 0);
      len     = $urandom_range(20, 60);
      repeat (len) begin
        r = pick_request();
        offer_request(r, 1'b0, '0);
        if (r.command != CMD_UNUSED) random_items++;
      end
    end

    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests over %0d frame-count settings, %0d long receiver holds",
             n_requests, n_settings, n_holds);
    $display("allocates %0d (evicting %0d), releases %0d + %0d of free frames, queries %0d, out of range %0d, unused %0d, mismatches %0d",
             n_alloc, n_evict, n_rel_ok, n_rel_free, n_query, n_range, n_unused, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
